/* rtl/core/smca_pkg.sv */
// smca_pkg: shared types, sizes and codes of the sparse COO matrix add unit.
// No dependencies; imported by every module of the block except smca_list_ram.
package smca_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ENTRY_W    = 64;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_MERGE  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  localparam logic [1:0] REG_FIRST_ROWS  = 2'd0;
  localparam logic [1:0] REG_FIRST_COLS  = 2'd1;
  localparam logic [1:0] REG_SECOND_ROWS = 2'd2;
  localparam logic [1:0] REG_SECOND_COLS = 2'd3;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] value;
  } coo_entry_t;

endpackage

/* rtl/core/sparse_matrix_coo_add_unit.sv */
// sparse_matrix_coo_add_unit: adds two sparse matrices given as sorted COO lists.
// Input channel in_valid/in_ready carries command, row, col, value. Command
// load A / load B appends an entry to a 16-entry list in RAM (no result
// unless the list is full, which gives one status item). Command merge
// checks the dimension registers, then walks both lists in (row, col) order and
// emits one item per distinct key, adding values of equal keys, last on the
// final one. Mismatched dimensions or two empty lists give one status item.
// Output channel out_valid/out_ready is a single output register; a stalled
// receiver holds the register and the sequencer waits, no item is lost.
// A merge reads each pair of list heads in state S_RD and emits in S_EMIT, the
// address-then-read turn of the list RAMs; S_EMIT waits while the output
// register is stalled. New items are taken only once the merge is done.
// Configuration (cfg_we, cfg_index, cfg_data) writes the four 16-bit
// dimension registers. Reset (rst, synchronous) clears the state, the counts,
// the registers and the output valid flag; RAM contents are not cleared.
module sparse_matrix_coo_add_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [15:0]        row,
  input  logic [15:0]        col,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_row,
  output logic [15:0]        out_col,
  output logic signed [31:0] out_value,
  output logic               has_entry,
  output logic [1:0]         status,
  output logic               last
);
  import smca_pkg::*;

  logic [15:0] first_rows;
  logic [15:0] first_cols;
  logic [15:0] second_rows;
  logic [15:0] second_cols;
  logic        dims_ok;
  logic        wr_en_a;
  logic        wr_en_b;
  logic [IDX_W-1:0] wr_addr;
  coo_entry_t  wr_data;
  logic [IDX_W-1:0] rd_addr_a;
  logic [IDX_W-1:0] rd_addr_b;
  coo_entry_t  rd_data_a;
  coo_entry_t  rd_data_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_rows  <= '0;
      first_cols  <= '0;
      second_rows <= '0;
      second_cols <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_ROWS:  first_rows  <= cfg_data;
        REG_FIRST_COLS:  first_cols  <= cfg_data;
        REG_SECOND_ROWS: second_rows <= cfg_data;
        REG_SECOND_COLS: second_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign dims_ok = (first_rows == second_rows) && (first_cols == second_cols);

  smca_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ENTRY_W), .ADDR_W(IDX_W)) u_list_a (
    .clk     (clk),
    .wr_en   (wr_en_a),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  smca_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ENTRY_W), .ADDR_W(IDX_W)) u_list_b (
    .clk     (clk),
    .wr_en   (wr_en_b),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  smca_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .row       (row),
    .col       (col),
    .value     (value),
    .dims_ok   (dims_ok),
    .wr_en_a   (wr_en_a),
    .wr_en_b   (wr_en_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .has_entry (has_entry),
    .status    (status),
    .last      (last)
  );

endmodule

/* rtl/core/smca_list_ram.sv */
// smca_list_ram: one-write, one-read synchronous RAM, registered read data.
// Holds one coordinate list; no package dependency.
module smca_list_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/smca_engine.sv */
// smca_engine: command decode, list counts, merge sequencer and output register.
// Depends on smca_pkg; drives the two smca_list_ram instances.
module smca_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [15:0]                  row,
  input  logic [15:0]                  col,
  input  logic signed [31:0]           value,
  input  logic                         dims_ok,
  output logic                         wr_en_a,
  output logic                         wr_en_b,
  output logic [smca_pkg::IDX_W-1:0]   wr_addr,
  output smca_pkg::coo_entry_t         wr_data,
  output logic [smca_pkg::IDX_W-1:0]   rd_addr_a,
  output logic [smca_pkg::IDX_W-1:0]   rd_addr_b,
  input  smca_pkg::coo_entry_t         rd_data_a,
  input  smca_pkg::coo_entry_t         rd_data_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_row,
  output logic [15:0]                  out_col,
  output logic signed [31:0]           out_value,
  output logic                         has_entry,
  output logic [1:0]                   status,
  output logic                         last
);
  import smca_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] j_next;
  logic             out_free;
  logic             out_load;
  logic             in_fire;
  logic             full_a;
  logic             full_b;
  logic             a_av;
  logic             b_av;
  logic             take_a;
  logic             take_b;
  logic [31:0]      key_a;
  logic [31:0]      key_b;
  coo_entry_t       pick;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign full_a   = (count_a == CNT_W'(LIST_DEPTH));
  assign full_b   = (count_b == CNT_W'(LIST_DEPTH));

  assign wr_en_a   = in_fire && (command == CMD_LOAD_A) && !full_a;
  assign wr_en_b   = in_fire && (command == CMD_LOAD_B) && !full_b;
  assign wr_addr   = (command == CMD_LOAD_A) ? count_a[IDX_W-1:0] : count_b[IDX_W-1:0];
  assign wr_data   = '{row: row, col: col, value: value};
  assign rd_addr_a = i[IDX_W-1:0];
  assign rd_addr_b = j[IDX_W-1:0];

  always_comb begin
    a_av   = (i < count_a);
    b_av   = (j < count_b);
    key_a  = {rd_data_a.row, rd_data_a.col};
    key_b  = {rd_data_b.row, rd_data_b.col};
    take_a = a_av && (!b_av || (key_a <= key_b));
    take_b = b_av && (!a_av || (key_b <= key_a));
    pick   = take_a ? rd_data_a : rd_data_b;
    if (take_a && take_b) begin
      pick.value = rd_data_a.value + rd_data_b.value;
    end
    i_next = take_a ? i + CNT_W'(1) : i;
    j_next = take_b ? j + CNT_W'(1) : j;
  end

  // output register gets a new item this cycle
  always_comb begin
    out_load = 1'b0;
    if (in_fire) begin
      case (command)
        CMD_LOAD_A: out_load = full_a;
        CMD_LOAD_B: out_load = full_b;
        CMD_MERGE:  out_load = !dims_ok || (count_a == '0 && count_b == '0);
        default:    out_load = 1'b0;
      endcase
    end else if (state == S_EMIT) begin
      out_load = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      i         <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (command)
              CMD_LOAD_A: begin
                if (full_a) begin
                  out_row   <= '0;
                  out_col   <= '0;
                  out_value <= '0;
                  has_entry <= 1'b0;
                  status    <= STAT_FULL;
                  last      <= 1'b1;
                end else begin
                  count_a <= count_a + CNT_W'(1);
                end
              end
              CMD_LOAD_B: begin
                if (full_b) begin
                  out_row   <= '0;
                  out_col   <= '0;
                  out_value <= '0;
                  has_entry <= 1'b0;
                  status    <= STAT_FULL;
                  last      <= 1'b1;
                end else begin
                  count_b <= count_b + CNT_W'(1);
                end
              end
              CMD_MERGE: begin
                if (!dims_ok || (count_a == '0 && count_b == '0)) begin
                  count_a   <= '0;
                  count_b   <= '0;
                  out_row   <= '0;
                  out_col   <= '0;
                  out_value <= '0;
                  has_entry <= 1'b0;
                  status    <= dims_ok ? STAT_OK : STAT_MISMATCH;
                  last      <= 1'b1;
                end else begin
                  i     <= '0;
                  j     <= '0;
                  state <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_row   <= pick.row;
            out_col   <= pick.col;
            out_value <= pick.value;
            has_entry <= 1'b1;
            status    <= STAT_OK;
            last      <= (i_next >= count_a) && (j_next >= count_b);
            i         <= i_next;
            j         <= j_next;
            if ((i_next >= count_a) && (j_next >= count_b)) begin
              count_a <= '0;
              count_b <= '0;
              state   <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/smca_checker.sv */
// smca_checker: port-level checks of the sparse COO add unit, bound to the top.
// Depends on smca_pkg for the status codes.
module smca_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_row,
  input logic [15:0] out_col,
  input logic [31:0] out_value,
  input logic        has_entry,
  input logic [1:0]  status,
  input logic        last
);
  import smca_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_value) && $stable(has_entry) && $stable(status) && $stable(last))
    else $error("output item changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_entry |-> last)
    else $error("status-only item without last");

  a_entry_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_entry |-> status == STAT_OK)
    else $error("entry item with error status");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_entry |-> out_row == '0 && out_col == '0 && out_value == '0)
    else $error("status-only item carries coordinates");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sparse_matrix_coo_add_unit smca_checker u_smca_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_row   (out_row),
  .out_col   (out_col),
  .out_value (out_value),
  .has_entry (has_entry),
  .status    (status),
  .last      (last)
);
